FILE: hw/rtl/half_weight_digit_split_core_macros.svh
// Assertion macros shared by the half-weight digit split RTL.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef HALF_WEIGHT_DIGIT_SPLIT_CORE_MACROS_SVH
`define HALF_WEIGHT_DIGIT_SPLIT_CORE_MACROS_SVH

// Same-cycle implication.
`define HWDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HWDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hwds_pkg.sv
// Shared types and constants for the half-weight digit split core.
// No dependencies; used by hwds_dp, hwds_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hwds_pkg;

  localparam int VALUE_W     = 64;
  localparam int RADIX_W     = 16;
  localparam int HALF_W      = VALUE_W / 2;

  localparam logic [RADIX_W-1:0] MIN_RADIX   = 16'd2;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 16'd2;

  // divider retires this many quotient bits per cycle
  localparam int DIV_BITS    = 4;
  localparam int DIV_CYCLES  = VALUE_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_STORE,
    ST_RD,
    ST_MUL,
    ST_PROD,
    ST_ACC,
    ST_WMUL,
    ST_WPROD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;         // take a new word, clear counters
    logic div_init;     // clear remainder and step counter
    logic div_step;     // retire DIV_BITS quotient bits
    logic store;        // write remainder as next digit
    logic rd;           // read digit at walk index
    logic mul_digit;    // partial products weight * digit
    logic mul_weight;   // partial products weight * base
    logic prod;         // fold partial products
    logic acc;          // sum += product
    logic wupd;         // weight = folded product, advance index
    logic load_result;  // move sum to output register
  } cmd_t;

  typedef struct packed {
    logic v_zero;       // remaining value is zero
    logic n_full;       // digit store holds MAX_DIGITS digits
    logic n_empty;      // no digits extracted
    logic div_last;     // final division step this cycle
    logic walk_stop;    // target reached or last digit done
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hwds_dp.sv
// Datapath: radix register, iterative divider, digit store and weighted walk.
// Depends on hwds_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "half_weight_digit_split_core_macros.svh"

module hwds_dp #(
  parameter int MAX_DIGITS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [hwds_pkg::RADIX_W-1:0]    cfg_wdata,
  input  wire logic [hwds_pkg::VALUE_W-1:0]    in_value,
  input  wire hwds_pkg::cmd_t                  cmd,
  output hwds_pkg::status_t                    status,
  output logic      [hwds_pkg::VALUE_W-1:0]    result
);

  localparam int CNTW = $clog2(MAX_DIGITS + 1);
  localparam int IDXW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [hwds_pkg::RADIX_W-1:0]   radix;
  logic [hwds_pkg::RADIX_W-1:0]   base;
  logic [hwds_pkg::VALUE_W-1:0]   q;
  logic [hwds_pkg::RADIX_W-1:0]   rem;
  logic [hwds_pkg::VALUE_W-1:0]   q_next;
  logic [hwds_pkg::RADIX_W-1:0]   rem_next;
  logic [hwds_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [CNTW-1:0]                n;
  logic [CNTW-1:0]                nz;
  logic [CNTW-1:0]                taken;
  logic [IDXW-1:0]                idx;
  logic [hwds_pkg::RADIX_W-1:0]   mem [MAX_DIGITS];
  logic [hwds_pkg::RADIX_W-1:0]   rd_data;
  logic [hwds_pkg::RADIX_W-1:0]   mul_op;
  logic [hwds_pkg::VALUE_W-1:0]   weight;
  logic [hwds_pkg::VALUE_W-1:0]   sum;
  logic [hwds_pkg::VALUE_W-1:0]   prod;
  logic [hwds_pkg::VALUE_W-1:0]   prod_next;
  logic [47:0]                    p_lo;
  logic [hwds_pkg::HALF_W-1:0]    p_hi;
  logic [47:0]                    m_lo;
  logic [47:0]                    m_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= hwds_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  assign base = (radix < hwds_pkg::MIN_RADIX) ? hwds_pkg::MIN_RADIX : radix;

  // restoring division, DIV_BITS bits per cycle; q turns into the quotient
  always_comb begin
    logic [hwds_pkg::RADIX_W:0] r;
    q_next   = q;
    rem_next = rem;
    for (int k = 0; k < hwds_pkg::DIV_BITS; k++) begin
      r      = {rem_next, q_next[hwds_pkg::VALUE_W-1]};
      q_next = {q_next[hwds_pkg::VALUE_W-2:0], 1'b0};
      if (r >= {1'b0, base}) begin
        r         = r - {1'b0, base};
        q_next[0] = 1'b1;
      end
      rem_next = r[hwds_pkg::RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q <= in_value;
    end else if (cmd.div_step) begin
      q <= q_next;
    end
    if (cmd.div_init) begin
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[n[IDXW-1:0]] <= rem;
    end
    if (cmd.rd) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n     <= '0;
      nz    <= '0;
      taken <= '0;
      idx   <= '0;
    end else if (cmd.load) begin
      n     <= '0;
      nz    <= '0;
      taken <= '0;
      idx   <= '0;
    end else begin
      if (cmd.store) begin
        n <= n + 1'b1;
        if (rem != '0) begin
          nz <= nz + 1'b1;
        end
      end
      if (cmd.mul_digit && (rd_data != '0)) begin
        taken <= taken + 1'b1;
      end
      if (cmd.wupd) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // 64 x 16 product mod 2^64 as two 32 x 16 partial products
  assign mul_op = cmd.mul_weight ? base : rd_data;
  assign m_lo   = weight[hwds_pkg::HALF_W-1:0] * mul_op;
  assign m_hi   = weight[hwds_pkg::VALUE_W-1:hwds_pkg::HALF_W] * mul_op;

  always_ff @(posedge clk) begin
    if (cmd.mul_digit || cmd.mul_weight) begin
      p_lo <= m_lo;
      p_hi <= m_hi[hwds_pkg::HALF_W-1:0];
    end
  end

  assign prod_next = {16'd0, p_lo} + {p_hi, {hwds_pkg::HALF_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      prod <= prod_next;
    end
    if (cmd.load) begin
      weight <= 64'd1;
    end else if (cmd.wupd) begin
      weight <= prod_next;
    end
    if (cmd.load) begin
      sum <= '0;
    end else if (cmd.acc) begin
      sum <= sum + prod;
    end
    if (cmd.load_result) begin
      result <= sum;
    end
  end

  assign status.v_zero    = (q == '0);
  assign status.n_full    = (n == CNTW'(MAX_DIGITS));
  assign status.n_empty   = (n == '0);
  assign status.div_last  = (div_cnt == hwds_pkg::DIV_CNT_W'(hwds_pkg::DIV_CYCLES - 1));
  assign status.walk_stop = (taken >= (nz >> 1)) || ((CNTW'(idx) + CNTW'(1)) == n);

  `HWDS_ASSERT_NOW(a_store_in_range, cmd.store, !status.n_full, "digit store overrun")
  `HWDS_ASSERT_NOW(a_walk_in_range, cmd.rd, CNTW'(idx) < n, "walk past last digit")

endmodule

`default_nettype wire

FILE: hw/rtl/hwds_ctrl.sv
// Controller: sequences division, digit store and walk; owns output valid.
// Depends on hwds_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "half_weight_digit_split_core_macros.svh"

module hwds_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  input  wire hwds_pkg::status_t  status,
  output hwds_pkg::cmd_t          cmd
);

  hwds_pkg::state_t state;
  hwds_pkg::state_t state_next;
  logic             out_free;
  logic             m_tvalid_next;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hwds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hwds_pkg::ST_IDLE:  if (s_tvalid) state_next = hwds_pkg::ST_CHECK;
      hwds_pkg::ST_CHECK: begin
        if (status.v_zero || status.n_full) begin
          state_next = status.n_empty ? hwds_pkg::ST_FIN : hwds_pkg::ST_RD;
        end else begin
          state_next = hwds_pkg::ST_DIV;
        end
      end
      hwds_pkg::ST_DIV:   if (status.div_last) state_next = hwds_pkg::ST_STORE;
      hwds_pkg::ST_STORE: state_next = hwds_pkg::ST_CHECK;
      hwds_pkg::ST_RD:    state_next = hwds_pkg::ST_MUL;
      hwds_pkg::ST_MUL:   state_next = hwds_pkg::ST_PROD;
      hwds_pkg::ST_PROD:  state_next = hwds_pkg::ST_ACC;
      hwds_pkg::ST_ACC:   begin
        state_next = status.walk_stop ? hwds_pkg::ST_FIN : hwds_pkg::ST_WMUL;
      end
      hwds_pkg::ST_WMUL:  state_next = hwds_pkg::ST_WPROD;
      hwds_pkg::ST_WPROD: state_next = hwds_pkg::ST_RD;
      hwds_pkg::ST_FIN:   if (out_free) state_next = hwds_pkg::ST_IDLE;
      default:            state_next = hwds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      hwds_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      hwds_pkg::ST_CHECK: cmd.div_init    = !(status.v_zero || status.n_full);
      hwds_pkg::ST_DIV:   cmd.div_step    = 1'b1;
      hwds_pkg::ST_STORE: cmd.store       = 1'b1;
      hwds_pkg::ST_RD:    cmd.rd          = 1'b1;
      hwds_pkg::ST_MUL:   cmd.mul_digit   = 1'b1;
      hwds_pkg::ST_PROD:  cmd.prod        = 1'b1;
      hwds_pkg::ST_ACC:   cmd.acc         = 1'b1;
      hwds_pkg::ST_WMUL:  cmd.mul_weight  = 1'b1;
      hwds_pkg::ST_WPROD: cmd.wupd        = 1'b1;
      hwds_pkg::ST_FIN:   cmd.load_result = out_free;
      default:            cmd             = '0;
    endcase
  end

  always_comb begin
    priority if (cmd.load_result) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  `HWDS_ASSERT_NOW(a_result_slot_free, cmd.load_result, out_free, "result overwrites pending word")
  `HWDS_ASSERT_NEXT(a_div_to_store, (state == hwds_pkg::ST_DIV) && status.div_last, state == hwds_pkg::ST_STORE, "division did not end in store")
  `HWDS_ASSERT_NEXT(a_result_shown, cmd.load_result, m_tvalid && (state == hwds_pkg::ST_IDLE), "finished word not presented")
  `HWDS_ASSERT_NOW(a_no_accept_busy, s_tready, state == hwds_pkg::ST_IDLE && !cmd.div_step, "input taken while busy")

endmodule

`default_nettype wire

FILE: hw/rtl/half_weight_digit_split_core.sv
// Half-weight digit split core: top level joining hwds_ctrl and hwds_dp.
// Per word: for each digit extracted, check, 16 divide steps of 4 bits and store; then
//   for each digit walked, read, multiply by weight, fold, accumulate and, unless the walk
//   stops, weight * radix and weight update, on two 32x16 partial products. Zero word: check, finish.
// Throughput: one word at a time, next accepted in the cycle after the result loads;
//   a result still waiting in the output register holds that load. Reset: rst sync, radix 2.
`timescale 1ns / 1ps
`default_nettype none

module half_weight_digit_split_core #(
  parameter int MAX_DIGITS = 64   // digit store depth, 1..64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // radix register write
  input  wire logic                          cfg_we,
  input  wire logic [hwds_pkg::RADIX_W-1:0]  cfg_wdata,   // [15:0] radix
  // input words
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [hwds_pkg::VALUE_W-1:0]  s_tdata,     // [63:0] value
  // result words
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [hwds_pkg::VALUE_W-1:0]  m_tdata      // [63:0] low_part
);

  // controller and datapath talk only through these two bundles
  hwds_pkg::cmd_t    cmd;
  hwds_pkg::status_t status;

  // sequencer: divide/store loop, then multiply/accumulate walk
  hwds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // radix reg, divider, digit memory, weight/sum arithmetic, result reg
  hwds_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_value  (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .result    (m_tdata)
  );

endmodule

`default_nettype wire
